FILE: hw/rtl/ring_queue_with_reverse_defines.svh
// assertion macros shared by the checker
`ifndef RING_QUEUE_WITH_REVERSE_DEFINES_SVH
`define RING_QUEUE_WITH_REVERSE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define RQR_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ring queue check failed");

// next-cycle implication, sampled on clk, off during reset
`define RQR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ring queue check failed");

`endif

FILE: hw/rtl/rqr_pkg.sv
`timescale 1ns / 1ps
package rqr_pkg;

  // request field widths
  localparam int unsigned OP_W     = 3;
  localparam int unsigned IN_ID_W  = 32;
  // result field widths
  localparam int unsigned OUT_ID_W = 32;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned ST_W     = 2;

  // parameter defaults
  localparam int unsigned DEPTH_DEF    = 16;
  localparam int unsigned ID_WIDTH_DEF = 32;

  typedef logic [OP_W-1:0] op_t;
  typedef logic [ST_W-1:0] status_t;

  // operation codes
  localparam op_t OP_PUSH   = 3'd0;
  localparam op_t OP_POP    = 3'd1;
  localparam op_t OP_LIST   = 3'd2;
  localparam op_t OP_REV    = 3'd3;
  localparam op_t OP_STATUS = 3'd4;

  // status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

endpackage

FILE: hw/rtl/rqr_if.sv
`timescale 1ns / 1ps
// request channel
interface rqr_in_if;
  import rqr_pkg::*;
  logic                      valid;
  logic                      ready;
  op_t                       op;
  logic signed [IN_ID_W-1:0] entry_id;

  modport source (output valid, op, entry_id, input ready);
  modport sink   (input valid, op, entry_id, output ready);
endinterface

// result channel
interface rqr_out_if;
  import rqr_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [OUT_ID_W-1:0] out_id;
  logic [POS_W-1:0]           position;
  logic [POS_W-1:0]           occupancy;
  logic signed [OUT_ID_W-1:0] head_id;
  status_t                    status;
  logic                       last;

  modport source (output valid, out_id, position, occupancy, head_id, status, last,
                  input ready);
  modport sink   (input valid, out_id, position, occupancy, head_id, status, last,
                  output ready);
endinterface

FILE: hw/rtl/ring_queue_with_reverse.sv
`timescale 1ns / 1ps
// Circular FIFO of entry identifiers held in a single-port-write, registered-read
// memory of DEPTH slots. Requests arrive on in_ch (op, entry_id), results leave
// on out_ch; both use valid/ready and move at an edge where both are high.
// Every result reports the occupancy and the head entry after the request;
// the final result of a request has last set.
// Push, status, pop or list on an empty queue, and reverse of fewer than two
// entries: the result is visible the cycle after the request is taken.
// Pop: the result waits in S_POPW for the memory read of the new head.
// List: per queued entry, one memory read (S_LRD) and then one result (S_LEM).
// Reverse: per swapped pair, two reads then two writes through the one memory
// port pair (S_RA to S_RD), then one result (S_REM).
// A new request is taken only when the previous one has finished and the
// result register is free or being emptied in the same cycle.
// A stalled receiver holds the result register; the sequencer waits with it.
// Reset (rst_n low at a clock edge) empties the queue; slot contents are not
// cleared, and a pop of the last entry may read an unwritten slot, whose value is not reported.
module ring_queue_with_reverse #(
  parameter int unsigned DEPTH    = rqr_pkg::DEPTH_DEF,
  parameter int unsigned ID_WIDTH = rqr_pkg::ID_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rqr_in_if.sink    in_ch,
  rqr_out_if.source out_ch
);
  import rqr_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_POPW = 4'd1;
  localparam logic [3:0] S_LRD  = 4'd2;
  localparam logic [3:0] S_LEM  = 4'd3;
  localparam logic [3:0] S_RA   = 4'd4;
  localparam logic [3:0] S_RB   = 4'd5;
  localparam logic [3:0] S_RC   = 4'd6;
  localparam logic [3:0] S_RD   = 4'd7;
  localparam logic [3:0] S_REM  = 4'd8;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [ID_WIDTH-1:0] ID_NONE = {ID_WIDTH{1'b1}};

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_LAST : p - 1'b1;
  endfunction

  function automatic logic [OUT_ID_W-1:0] to_out(input logic [ID_WIDTH-1:0] v);
    return OUT_ID_W'(64'(v));
  endfunction

  // slot memory
  logic [ID_WIDTH-1:0] slots_mem [DEPTH];
  logic                rd_en;
  logic [PTR_W-1:0]    rd_addr;
  logic [ID_WIDTH-1:0] rd_data_r;
  logic                wr_en;
  logic [PTR_W-1:0]    wr_addr;
  logic [ID_WIDTH-1:0] wr_data;

  // control and pointer state
  logic [3:0]          state_r, state_nxt;
  logic [PTR_W-1:0]    head_r, head_nxt;
  logic [PTR_W-1:0]    tail_r, tail_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ID_WIDTH-1:0] head_val_r, head_val_nxt;
  logic [PTR_W-1:0]    lo_r, lo_nxt;
  logic [PTR_W-1:0]    hi_r, hi_nxt;
  logic [CNT_W-1:0]    step_r, step_nxt;
  logic [ID_WIDTH-1:0] tmp_r, tmp_nxt;

  // result register
  logic                out_valid_r;
  logic [OUT_ID_W-1:0] out_id_r;
  logic [POS_W-1:0]    pos_r;
  logic [POS_W-1:0]    occ_r;
  logic [OUT_ID_W-1:0] hid_r;
  status_t             st_r;
  logic                last_r;

  logic                ld;
  logic [OUT_ID_W-1:0] ld_id;
  logic [POS_W-1:0]    ld_pos;
  status_t             ld_st;
  logic                ld_last;

  logic                out_free;
  logic                accept;
  logic [ID_WIDTH-1:0] id_in;
  logic [CNT_W-1:0]    step_inc;
  status_t             cnt_st;

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign accept = in_ch.valid && in_ch.ready;
  assign id_in = ID_WIDTH'({32'd0, in_ch.entry_id});
  assign step_inc = step_r + 1'b1;
  assign cnt_st = (cnt_r == '0) ? ST_EMPTY : ST_OK;

  // memory ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= slots_mem[rd_addr];
    end
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    cnt_nxt      = cnt_r;
    head_val_nxt = head_val_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    step_nxt     = step_r;
    tmp_nxt      = tmp_r;
    rd_en        = 1'b0;
    rd_addr      = lo_r;
    wr_en        = 1'b0;
    wr_addr      = lo_r;
    wr_data      = rd_data_r;
    ld           = 1'b0;
    ld_id        = '0;
    ld_pos       = '0;
    ld_st        = ST_OK;
    ld_last      = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_ch.op)
            OP_PUSH: begin
              ld = 1'b1;
              if (cnt_r == CNT_FULL) begin
                ld_st = ST_FULL;
              end else begin
                wr_en    = 1'b1;
                wr_addr  = tail_r;
                wr_data  = id_in;
                tail_nxt = ptr_inc(tail_r);
                cnt_nxt  = cnt_r + 1'b1;
                if (cnt_r == '0) begin
                  head_val_nxt = id_in;
                end
              end
            end
            OP_POP: begin
              if (cnt_r == '0) begin
                ld    = 1'b1;
                ld_id = to_out(ID_NONE);
                ld_st = ST_EMPTY;
              end else begin
                // old head leaves now, new head comes back from memory
                tmp_nxt   = head_val_r;
                rd_en     = 1'b1;
                rd_addr   = ptr_inc(head_r);
                head_nxt  = ptr_inc(head_r);
                cnt_nxt   = cnt_r - 1'b1;
                state_nxt = S_POPW;
              end
            end
            OP_LIST: begin
              if (cnt_r == '0) begin
                ld    = 1'b1;
                ld_st = ST_EMPTY;
              end else begin
                lo_nxt    = head_r;
                step_nxt  = '0;
                state_nxt = S_LRD;
              end
            end
            OP_REV: begin
              if (cnt_r > CNT_W'(1)) begin
                lo_nxt    = head_r;
                hi_nxt    = ptr_dec(tail_r);
                step_nxt  = '0;
                state_nxt = S_RA;
              end else begin
                ld    = 1'b1;
                ld_st = cnt_st;
              end
            end
            default: begin
              ld    = 1'b1;
              ld_st = cnt_st;
            end
          endcase
        end
      end

      // pop result once the new head is read
      S_POPW: begin
        if (out_free) begin
          ld           = 1'b1;
          ld_id        = to_out(tmp_r);
          head_val_nxt = rd_data_r;
          state_nxt    = S_IDLE;
        end
      end

      // list walk: read one slot, then emit it
      S_LRD: begin
        rd_en     = 1'b1;
        rd_addr   = lo_r;
        state_nxt = S_LEM;
      end

      S_LEM: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_id     = to_out(rd_data_r);
          ld_pos    = POS_W'(step_inc);
          ld_last   = (step_inc == cnt_r);
          lo_nxt    = ptr_inc(lo_r);
          step_nxt  = step_inc;
          state_nxt = ld_last ? S_IDLE : S_LRD;
        end
      end

      // reverse: read low and high slots, write them back crossed
      S_RA: begin
        rd_en     = 1'b1;
        rd_addr   = lo_r;
        state_nxt = S_RB;
      end

      S_RB: begin
        rd_en     = 1'b1;
        rd_addr   = hi_r;
        tmp_nxt   = rd_data_r;
        state_nxt = S_RC;
      end

      S_RC: begin
        wr_en   = 1'b1;
        wr_addr = lo_r;
        wr_data = rd_data_r;
        // first pair: old tail entry becomes the head
        if (step_r == '0) begin
          head_val_nxt = rd_data_r;
        end
        state_nxt = S_RD;
      end

      S_RD: begin
        wr_en     = 1'b1;
        wr_addr   = hi_r;
        wr_data   = tmp_r;
        lo_nxt    = ptr_inc(lo_r);
        hi_nxt    = ptr_dec(hi_r);
        step_nxt  = step_inc;
        state_nxt = (step_inc == (cnt_r >> 1)) ? S_REM : S_RA;
      end

      S_REM: begin
        if (out_free) begin
          ld        = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cnt_r   <= cnt_nxt;
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    head_val_r <= head_val_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    step_r     <= step_nxt;
    tmp_r      <= tmp_nxt;
    if (ld) begin
      out_id_r <= ld_id;
      pos_r    <= ld_pos;
      occ_r    <= POS_W'(cnt_nxt);
      hid_r    <= (cnt_nxt == '0) ? to_out(ID_NONE) : to_out(head_val_nxt);
      st_r     <= ld_st;
      last_r   <= ld_last;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_id    = out_id_r;
  assign out_ch.position  = pos_r;
  assign out_ch.occupancy = occ_r;
  assign out_ch.head_id   = hid_r;
  assign out_ch.status    = st_r;
  assign out_ch.last      = last_r;

endmodule

FILE: hw/rtl/rqr_checker.sv
`timescale 1ns / 1ps
`include "ring_queue_with_reverse_defines.svh"
module rqr_checker #(
  parameter int unsigned DEPTH    = rqr_pkg::DEPTH_DEF,
  parameter int unsigned ID_WIDTH = rqr_pkg::ID_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rqr_pkg::OUT_ID_W-1:0]  out_id,
  input logic [rqr_pkg::POS_W-1:0]     out_position,
  input logic [rqr_pkg::POS_W-1:0]     out_occupancy,
  input logic [rqr_pkg::OUT_ID_W-1:0]  out_head_id,
  input rqr_pkg::status_t              out_status
);
  import rqr_pkg::*;

  localparam logic [OUT_ID_W-1:0] HEAD_NONE = OUT_ID_W'(64'({ID_WIDTH{1'b1}}));
  localparam logic [POS_W-1:0]    OCC_FULL  = POS_W'(DEPTH);

  logic res_full;
  logic res_empty;
  logic res_none;

  // result classes
  assign res_full  = out_valid && (out_status == ST_FULL);
  assign res_empty = out_valid && (out_status == ST_EMPTY);
  assign res_none  = out_valid && (out_occupancy == '0);

  // refused push only when the queue is full, and it carries no identifier
  `RQR_ASSERT_IMPL(a_full_only_when_full, res_full, out_occupancy == OCC_FULL && out_id == '0)
  // empty status only when nothing is queued
  `RQR_ASSERT_IMPL(a_empty_means_none, res_empty, out_occupancy == '0)
  // empty queue reports the no-head marker
  `RQR_ASSERT_IMPL(a_head_none_when_empty, res_none, out_head_id == HEAD_NONE)
  // listed position never beyond the occupancy
  `RQR_ASSERT_IMPL(a_pos_in_range, out_valid && out_position != '0, out_position <= out_occupancy)
  // a stalled result stays offered
  `RQR_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid)

endmodule

bind ring_queue_with_reverse rqr_checker #(
  .DEPTH    (DEPTH),
  .ID_WIDTH (ID_WIDTH)
) u_rqr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_id        (out_ch.out_id),
  .out_position  (out_ch.position),
  .out_occupancy (out_ch.occupancy),
  .out_head_id   (out_ch.head_id),
  .out_status    (out_ch.status)
);

FILE: tb/tb_ring_queue_with_reverse.sv
`timescale 1ns / 1ps
module tb_ring_queue_with_reverse;
  import rqr_pkg::*;

  localparam int unsigned DEPTH      = DEPTH_DEF;
  localparam int          IDLE_LIMIT = 2000;
  localparam int          RAND_ITEMS = 175;
  localparam int          QUIET_FROM = 140;
  localparam int          MAX_SHOWN  = 10;

  // selectors the block treats as status only
  localparam op_t OP_SPARE_LO = 3'd5;
  localparam op_t OP_SPARE_HI = 3'd7;

  typedef logic signed [OUT_ID_W-1:0] id_t;

  typedef struct packed {
    id_t              out_id;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] occupancy;
    id_t              head_id;
    status_t          status;
    logic             last;
  } result_t;

  typedef struct {
    op_t     op;
    id_t     id;
    int      reps;
    bit      typed;
    result_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  rqr_in_if  in_if ();
  rqr_out_if out_if ();

  ring_queue_with_reverse u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #5 clk = ~clk;

  // shadow queue contents, head first
  id_t      held_ids[$];
  result_t  step_results[$];
  result_t  pending_results[$];
  dir_row_t dir_rows[$];

  int fault_count = 0;
  int idle_cycles = 0;
  bit quiet_tail  = 1'b0;

  // one result with occupancy and head taken from the shadow queue
  function automatic result_t make_result(id_t out_id, int pos, status_t st, bit last);
    result_t r;
    r.out_id    = out_id;
    r.position  = POS_W'(pos);
    r.occupancy = POS_W'(held_ids.size());
    r.head_id   = (held_ids.size() != 0) ? held_ids[0] : -1;
    r.status    = st;
    r.last      = last;
    return r;
  endfunction

  // apply one request to the shadow queue and collect its results
  function automatic void queue_step(op_t op, id_t id);
    id_t tmp;
    int  n;
    step_results.delete();
    n = held_ids.size();
    case (op)
      OP_PUSH: begin
        if (n >= DEPTH) begin
          step_results.push_back(make_result(0, 0, ST_FULL, 1'b1));
        end else begin
          held_ids.push_back(id);
          step_results.push_back(make_result(0, 0, ST_OK, 1'b1));
        end
      end
      OP_POP: begin
        if (n == 0) begin
          step_results.push_back(make_result(-1, 0, ST_EMPTY, 1'b1));
        end else begin
          tmp = held_ids.pop_front();
          step_results.push_back(make_result(tmp, 0, ST_OK, 1'b1));
        end
      end
      OP_LIST: begin
        if (n == 0) begin
          step_results.push_back(make_result(0, 0, ST_EMPTY, 1'b1));
        end else begin
          for (int i = 0; i < n; i++)
            step_results.push_back(make_result(held_ids[i], i + 1, ST_OK, i == n - 1));
        end
      end
      OP_REV: begin
        for (int i = 0; i < n / 2; i++) begin
          tmp = held_ids[i];
          held_ids[i] = held_ids[n - 1 - i];
          held_ids[n - 1 - i] = tmp;
        end
        step_results.push_back(make_result(0, 0, (n == 0) ? ST_EMPTY : ST_OK, 1'b1));
      end
      default: begin
        step_results.push_back(make_result(0, 0, (n == 0) ? ST_EMPTY : ST_OK, 1'b1));
      end
    endcase
  endfunction

  function automatic void add_row(op_t op, id_t id, int reps, bit typed,
                                  id_t e_id, int e_occ, id_t e_head, status_t e_st);
    dir_row_t row;
    row.op    = op;
    row.id    = id;
    row.reps  = reps;
    row.typed = typed;
    row.res   = '{out_id: e_id, position: '0, occupancy: POS_W'(e_occ),
                  head_id: e_head, status: e_st, last: 1'b1};
    dir_rows.push_back(row);
  endfunction

  // identifiers, with the extremes mixed in
  function automatic id_t pick_id();
    case ($urandom_range(0, 11))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return -1;
      3:       return 0;
      default: return id_t'($urandom());
    endcase
  endfunction

  function automatic op_t pick_op();
    int w;
    w = $urandom_range(0, 99);
    if (w < 40)      return OP_PUSH;
    else if (w < 68) return OP_POP;
    else if (w < 78) return OP_LIST;
    else if (w < 87) return OP_REV;
    else if (w < 93) return OP_STATUS;
    else             return op_t'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
  endfunction

  // hold a request until taken; valid stays high for back-to-back requests
  task automatic send_request(op_t op, id_t id, bit typed, result_t typed_res);
    in_if.valid    <= 1'b1;
    in_if.op       <= op;
    in_if.entry_id <= id;
    do @(posedge clk); while (!in_if.ready);
    queue_step(op, id);
    if (typed) begin
      pending_results.push_back(typed_res);
    end else begin
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
    end
  endtask

  // sender gap with junk on the payload
  task automatic sender_gap(int cycles);
    in_if.valid    <= 1'b0;
    in_if.op       <= op_t'($urandom());
    in_if.entry_id <= id_t'($urandom());
    repeat (cycles) @(posedge clk);
  endtask

  task automatic random_request(op_t op);
    if (!quiet_tail && $urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 9));
    send_request(op, pick_id(), 1'b0, '0);
  endtask

  // result checker
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_id: out_if.out_id, position: out_if.position,
              occupancy: out_if.occupancy, head_id: out_if.head_id,
              status: out_if.status, last: out_if.last};
      if (pending_results.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_SHOWN)
          $display("unexpected result: id %0d pos %0d occ %0d head %0d st %0d last %0d",
                   got.out_id, got.position, got.occupancy, got.head_id, got.status,
                   got.last);
      end else begin
        want = pending_results.pop_front();
        if (got.out_id !== want.out_id || got.position !== want.position ||
            got.occupancy !== want.occupancy || got.head_id !== want.head_id ||
            got.status !== want.status || got.last !== want.last) begin
          fault_count++;
          if (fault_count <= MAX_SHOWN) begin
            $display("mismatch exp: id %0d pos %0d occ %0d head %0d st %0d last %0d",
                     want.out_id, want.position, want.occupancy, want.head_id,
                     want.status, want.last);
            $display("         got: id %0d pos %0d occ %0d head %0d st %0d last %0d",
                     got.out_id, got.position, got.occupancy, got.head_id, got.status,
                     got.last);
          end
        end
      end
    end
  end

  // cycles with no request or result moving
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("** ring_queue_with_reverse: FAILED **");
    $finish;
  end

  // receiver stalls in bursts, with long open stretches now and then
  initial begin
    int run;
    out_if.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      run = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
      repeat (run) @(posedge clk);
    end
  end

  // stimulus
  initial begin
    int  sent;
    int  k;
    bit  pressure_done;
    op_t op;

    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.op       = OP_STATUS;
    in_if.entry_id = '0;
    sent           = 0;
    pressure_done  = 1'b0;

    // directed table: empty queue, extremes, order reversal, full queue
    add_row(OP_STATUS,   0,             1,  1, 0,  0, -1,            ST_EMPTY);
    add_row(OP_POP,      0,             1,  1, -1, 0, -1,            ST_EMPTY);
    add_row(OP_LIST,     0,             1,  1, 0,  0, -1,            ST_EMPTY);
    add_row(OP_REV,      0,             1,  1, 0,  0, -1,            ST_EMPTY);
    add_row(OP_SPARE_HI, -1,            1,  1, 0,  0, -1,            ST_EMPTY);
    add_row(OP_PUSH,     32'h7fff_ffff, 1,  1, 0,  1, 32'h7fff_ffff, ST_OK);
    add_row(OP_REV,      0,             1,  0, 0,  0, 0,             ST_OK);
    add_row(OP_PUSH,     32'h8000_0000, 1,  0, 0,  0, 0,             ST_OK);
    add_row(OP_PUSH,     -1,            1,  0, 0,  0, 0,             ST_OK);
    add_row(OP_PUSH,     0,             1,  0, 0,  0, 0,             ST_OK);
    add_row(OP_LIST,     0,             1,  0, 0,  0, 0,             ST_OK);
    add_row(OP_REV,      0,             1,  0, 0,  0, 0,             ST_OK);
    add_row(OP_LIST,     0,             1,  0, 0,  0, 0,             ST_OK);
    add_row(OP_SPARE_LO, 32'h1234_5678, 1,  0, 0,  0, 0,             ST_OK);
    add_row(OP_POP,      0,             1,  0, 0,  0, 0,             ST_OK);
    add_row(OP_PUSH,     32'h5a5a_0000, 13, 0, 0,  0, 0,             ST_OK);
    add_row(OP_PUSH,     32'h0bad_f00d, 1,  0, 0,  0, 0,             ST_OK);
    add_row(OP_LIST,     0,             1,  0, 0,  0, 0,             ST_OK);
    add_row(OP_REV,      0,             1,  0, 0,  0, 0,             ST_OK);
    add_row(OP_LIST,     0,             1,  0, 0,  0, 0,             ST_OK);
    add_row(OP_POP,      0,             1,  0, 0,  0, 0,             ST_OK);
    add_row(OP_REV,      0,             1,  0, 0,  0, 0,             ST_OK);
    add_row(OP_LIST,     0,             1,  0, 0,  0, 0,             ST_OK);
    add_row(OP_STATUS,   0,             1,  0, 0,  0, 0,             ST_OK);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) begin
      for (int i = 0; i < dir_rows[r].reps; i++) begin
        if ($urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 9));
        send_request(dir_rows[r].op, dir_rows[r].id + i, dir_rows[r].typed,
                     dir_rows[r].res);
      end
    end

    // random part in segments: fill, drain, reorder, or mixed traffic
    while (sent < RAND_ITEMS) begin
      quiet_tail = (sent >= QUIET_FROM);
      if (!pressure_done && sent >= RAND_ITEMS / 2) begin
        // hold off until the block has delivered everything
        in_if.valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        pressure_done = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1: begin
          k = DEPTH - held_ids.size() + $urandom_range(1, 2);
          repeat (k) random_request(OP_PUSH);
          sent += k;
        end
        2, 3: begin
          k = held_ids.size() + $urandom_range(1, 2);
          repeat (k) random_request(OP_POP);
          sent += k;
        end
        4: begin
          random_request(OP_REV);
          random_request(OP_LIST);
          sent += 2;
        end
        default: begin
          k = $urandom_range(4, 12);
          repeat (k) begin
            op = pick_op();
            random_request(op);
          end
          sent += k;
        end
      endcase
    end

    // drain and let the block settle
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (40) @(posedge clk);

    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("** ring_queue_with_reverse: PASSED **");
    end else begin
      $display("** ring_queue_with_reverse: FAILED **");
    end
    $finish;
  end

endmodule
